>>> hw/rtl/lmfs_pkg.sv
// Shared types and constants for the LED matrix framebuffer scanner.
// Used by lmfs_rect_walk and led_matrix_framebuffer_scanner; depends on nothing.
`default_nettype none

package lmfs_pkg;

  // Field widths of the stream beats.
  localparam int OP_W        = 3;
  localparam int ROW_IDX_W   = 5;
  localparam int COL_IDX_W   = 6;
  localparam int PIX_W       = 8;
  localparam int RECT_W_W    = 7;
  localparam int RECT_H_W    = 6;
  localparam int SUM_W       = 19;
  localparam int RGB_W       = 3;
  localparam int ROW_ADDR_W  = 4;
  localparam int COL_SH_W    = 6;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (SUM_W + 1 + 2 * RGB_W + ROW_ADDR_W + COL_SH_W);

  // Width used for the rectangle edge checks.
  localparam int FIT_W = 9;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE      = 3'd0,
    OP_ADD        = 3'd1,
    OP_CLEAR_ALL  = 3'd2,
    OP_CLEAR_RECT = 3'd3,
    OP_AREA_SUM   = 3'd4,
    OP_SCAN_STEP  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    W_IDLE,
    W_RUN,
    W_DRAIN,
    W_DONE
  } walk_state_t;

  // Request handed to the rectangle walker.
  typedef struct packed {
    logic                 sum_mode;
    logic                 report;
    logic                 full;
    logic [ROW_IDX_W-1:0] row;
    logic [COL_IDX_W-1:0] col;
    logic [RECT_W_W-1:0]  width;
    logic [RECT_H_W-1:0]  height;
  } walk_cmd_t;

  // Answer of a rectangle operation.
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic             rejected;
  } walk_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/lmfs_ram.sv
// Generic synchronous RAM: one write port and two read ports with registered data.
// No dependencies.
`default_nettype none

module lmfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic                     re_b,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lmfs_rect_walk.sv
// Rectangle walker: steps through a rectangle of the pixel store one entry per cycle,
// clearing it or summing it. Depends on lmfs_pkg.
`default_nettype none

module lmfs_rect_walk #(
  parameter int PANEL_ROWS = 32,
  parameter int PANEL_COLS = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     start,
  input  wire lmfs_pkg::walk_cmd_t                      cmd,
  output logic                                          busy,
  output logic                                          mem_re,
  output logic                                          mem_we,
  output logic [$clog2(PANEL_ROWS*PANEL_COLS)-1:0]      mem_addr,
  input  wire logic [lmfs_pkg::PIX_W-1:0]               rdata,
  input  wire logic                                     res_take,
  output lmfs_pkg::walk_res_t                           res
);

  import lmfs_pkg::*;

  localparam int AW  = $clog2(PANEL_ROWS * PANEL_COLS);
  localparam int RCW = $clog2(PANEL_ROWS + 1);
  localparam int CCW = $clog2(PANEL_COLS + 1);

  walk_state_t      state_r, state_nxt;
  logic [RCW-1:0]   row_r, row_nxt, row_end_r, row_end_nxt, row_inc;
  logic [CCW-1:0]   col_r, col_nxt, col0_r, col0_nxt, col_end_r, col_end_nxt, col_inc;
  logic             sum_mode_r, sum_mode_nxt;
  logic             report_r, report_nxt;
  logic             rejected_r, rejected_nxt;
  logic             rd_pend_r;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic             fits, empty;

  assign fits = (FIT_W'(cmd.col) + FIT_W'(cmd.width) <= FIT_W'(PANEL_COLS)) &&
                (FIT_W'(cmd.row) + FIT_W'(cmd.height) <= FIT_W'(PANEL_ROWS));
  assign empty = (cmd.width == '0) || (cmd.height == '0);

  assign row_inc  = row_r + RCW'(1);
  assign col_inc  = col_r + CCW'(1);
  assign mem_addr = AW'(32'(row_r) * PANEL_COLS + 32'(col_r));

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    col0_nxt     = col0_r;
    row_end_nxt  = row_end_r;
    col_end_nxt  = col_end_r;
    sum_mode_nxt = sum_mode_r;
    report_nxt   = report_r;
    rejected_nxt = rejected_r;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    acc_nxt      = acc_r;
    if (rd_pend_r) begin
      acc_nxt = acc_r + SUM_W'(rdata);
    end
    unique case (state_r)
      W_IDLE: begin
        if (start) begin
          acc_nxt      = '0;
          sum_mode_nxt = cmd.sum_mode;
          report_nxt   = cmd.report;
          rejected_nxt = !cmd.full && !fits;
          if (cmd.full) begin
            row_nxt     = '0;
            col_nxt     = '0;
            col0_nxt    = '0;
            row_end_nxt = RCW'(PANEL_ROWS);
            col_end_nxt = CCW'(PANEL_COLS);
            state_nxt   = W_RUN;
          end else if (!fits || empty) begin
            state_nxt = cmd.report ? W_DONE : W_IDLE;
          end else begin
            row_nxt     = RCW'(cmd.row);
            col_nxt     = CCW'(cmd.col);
            col0_nxt    = CCW'(cmd.col);
            row_end_nxt = RCW'(FIT_W'(cmd.row) + FIT_W'(cmd.height));
            col_end_nxt = CCW'(FIT_W'(cmd.col) + FIT_W'(cmd.width));
            state_nxt   = W_RUN;
          end
        end
      end
      W_RUN: begin
        mem_re = sum_mode_r;
        mem_we = !sum_mode_r;
        if (col_inc == col_end_r) begin
          col_nxt = col0_r;
          row_nxt = row_inc;
          if (row_inc == row_end_r) begin
            if (sum_mode_r) begin
              state_nxt = W_DRAIN;
            end else begin
              state_nxt = report_r ? W_DONE : W_IDLE;
            end
          end
        end else begin
          col_nxt = col_inc;
        end
      end
      W_DRAIN: begin
        state_nxt = W_DONE;
      end
      W_DONE: begin
        if (res_take) begin
          state_nxt = W_IDLE;
        end
      end
      default: begin
        state_nxt = W_IDLE;
      end
    endcase
  end

  // After reset the walker sweeps the whole panel to clear the store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= W_RUN;
      row_r      <= '0;
      col_r      <= '0;
      col0_r     <= '0;
      row_end_r  <= RCW'(PANEL_ROWS);
      col_end_r  <= CCW'(PANEL_COLS);
      sum_mode_r <= 1'b0;
      report_r   <= 1'b0;
      rd_pend_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      col0_r     <= col0_nxt;
      row_end_r  <= row_end_nxt;
      col_end_r  <= col_end_nxt;
      sum_mode_r <= sum_mode_nxt;
      report_r   <= report_nxt;
      rd_pend_r  <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    rejected_r <= rejected_nxt;
  end

  assign busy         = (state_r != W_IDLE);
  assign res.valid    = (state_r == W_DONE);
  assign res.sum      = acc_r;
  assign res.rejected = rejected_r;

endmodule

`default_nettype wire

>>> hw/rtl/led_matrix_framebuffer_scanner.sv
// Top level of the LED matrix framebuffer scanner: pixel pipeline, scan counter and
// result register. Depends on lmfs_pkg, lmfs_ram and lmfs_rect_walk.
`default_nettype none

// The block keeps a byte per pixel of a PANEL_ROWS x PANEL_COLS RGB panel in one
// synchronous RAM and serves six operations carried in in_tuser: write a pixel, add a
// byte into a pixel (8-bit wrap), clear the whole store, clear a rectangle, sum a
// rectangle, and one scan step. Writes, adds and scan steps take one beat per cycle
// while no walk runs and no scan result waits on a full result register: each reads
// the RAM when accepted and finishes in the second stage, where an add writes its sum
// back; a read that hits the entry being written in the same cycle takes the new byte
// by forwarding. Rectangle clear and sum walk the rectangle one entry per cycle
// through the single write port or read port A, so they hold in_tready low while
// they walk, while a sum waits for its last read, and until the answer is handed to
// the result register. Clear all walks every entry of the store, and the same clearing
// pass runs right after reset before in_tready first rises. A rectangle that passes
// the panel edge is refused at once with rejected set. Each scan step returns bits 2..0
// of the pixel in the current row and of the pixel HALF_ROWS rows below, the row pair
// address, the column, and out_tlast at the last column, where the row should be
// latched; the column then advances and wraps into the next row pair. The result
// register lets a new beat in while an earlier result still waits on out_tready.

module led_matrix_framebuffer_scanner #(
  parameter int PANEL_ROWS = 32,
  parameter int PANEL_COLS = 64,
  parameter int HALF_ROWS  = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // Fields from bit 0 up: row_index[4:0], col_index[10:5], pixel_value[18:11],
  // rect_width[25:19], rect_height[31:26].
  input  wire logic [lmfs_pkg::IN_TDATA_W-1:0]      in_tdata,
  // Fields: operation[2:0].
  input  wire logic [lmfs_pkg::OP_W-1:0]            in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // Fields from bit 0 up: area_sum[18:0], rejected[19], upper_rgb[22:20],
  // lower_rgb[25:23], row_address[29:26], column_shifted[35:30], zero fill[39:36].
  output logic [lmfs_pkg::OUT_TDATA_W-1:0]          out_tdata,
  // Fields: result_kind[0].
  output logic                                      out_tuser,
  // latch_row: set on the scan beat of the last column.
  output logic                                      out_tlast
);

  import lmfs_pkg::*;

  localparam int DEPTH  = PANEL_ROWS * PANEL_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SRW    = $clog2(HALF_ROWS);
  localparam int SCW    = $clog2(PANEL_COLS);

  // Input beat fields.
  op_t                  in_op;
  logic [ROW_IDX_W-1:0] in_row;
  logic [COL_IDX_W-1:0] in_col;
  logic [PIX_W-1:0]     in_pix;
  logic [RECT_W_W-1:0]  in_width;
  logic [RECT_H_W-1:0]  in_height;
  logic                 in_accept;

  assign in_op     = op_t'(in_tuser);
  assign in_row    = in_tdata[4:0];
  assign in_col    = in_tdata[10:5];
  assign in_pix    = in_tdata[18:11];
  assign in_width  = in_tdata[25:19];
  assign in_height = in_tdata[31:26];
  assign in_accept = in_tvalid && in_tready;

  // Scan position.
  logic [SRW-1:0] scan_row_r, scan_row_nxt;
  logic [SCW-1:0] scan_col_r, scan_col_nxt;
  logic           scan_latch, scan_up_ok, scan_lo_ok;
  logic [ADDR_W-1:0] scan_up_addr, scan_lo_addr;

  assign scan_latch = (scan_col_r == SCW'(PANEL_COLS - 1));
  assign scan_up_ok = (32'(scan_row_r) < PANEL_ROWS);
  assign scan_lo_ok = (32'(scan_row_r) + HALF_ROWS < PANEL_ROWS);
  assign scan_up_addr = scan_up_ok ?
      ADDR_W'(32'(scan_row_r) * PANEL_COLS + 32'(scan_col_r)) : '0;
  assign scan_lo_addr = scan_lo_ok ?
      ADDR_W'((32'(scan_row_r) + HALF_ROWS) * PANEL_COLS + 32'(scan_col_r)) : '0;

  // Issue decode.
  logic              pix_ok;
  logic [ADDR_W-1:0] pix_addr;
  logic [ADDR_W-1:0] iss_addr_a, iss_addr_b;
  logic              iss_to_s1, iss_we, iss_add, iss_scan, iss_walk;
  walk_cmd_t         walk_cmd;

  assign pix_ok = (FIT_W'(in_row) < FIT_W'(PANEL_ROWS)) && (FIT_W'(in_col) < FIT_W'(PANEL_COLS));
  assign pix_addr = ADDR_W'(32'(in_row) * PANEL_COLS + 32'(in_col));

  always_comb begin
    iss_addr_a        = '0;
    iss_addr_b        = '0;
    iss_to_s1         = 1'b0;
    iss_we            = 1'b0;
    iss_add           = 1'b0;
    iss_scan          = 1'b0;
    iss_walk          = 1'b0;
    walk_cmd.sum_mode = 1'b0;
    walk_cmd.report   = 1'b0;
    walk_cmd.full     = 1'b0;
    walk_cmd.row      = in_row;
    walk_cmd.col      = in_col;
    walk_cmd.width    = in_width;
    walk_cmd.height   = in_height;
    unique case (in_op) inside
      OP_WRITE, OP_ADD: begin
        // A pixel outside the panel is dropped without touching the store.
        iss_to_s1  = pix_ok;
        iss_we     = pix_ok;
        iss_add    = (in_op == OP_ADD);
        iss_addr_a = pix_addr;
      end
      OP_CLEAR_ALL: begin
        iss_walk      = 1'b1;
        walk_cmd.full = 1'b1;
      end
      OP_CLEAR_RECT: begin
        iss_walk        = 1'b1;
        walk_cmd.report = 1'b1;
      end
      OP_AREA_SUM: begin
        iss_walk          = 1'b1;
        walk_cmd.report   = 1'b1;
        walk_cmd.sum_mode = 1'b1;
      end
      OP_SCAN_STEP: begin
        iss_to_s1  = 1'b1;
        iss_scan   = 1'b1;
        iss_addr_a = scan_up_addr;
        iss_addr_b = scan_lo_addr;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    scan_row_nxt = scan_row_r;
    scan_col_nxt = scan_col_r;
    if (in_accept && iss_scan) begin
      if (scan_latch) begin
        scan_col_nxt = '0;
        scan_row_nxt = (scan_row_r == SRW'(HALF_ROWS - 1)) ? '0 : scan_row_r + SRW'(1);
      end else begin
        scan_col_nxt = scan_col_r + SCW'(1);
      end
    end
  end

  // Second stage: RAM data is back, a write or an add finishes, a scan result is formed.
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_we_r, s1_add_r, s1_scan_r;
  logic [ADDR_W-1:0]     s1_addr_r;
  logic [PIX_W-1:0]      s1_val_r;
  logic                  s1_up_ok_r, s1_lo_ok_r, s1_latch_r;
  logic [ROW_ADDR_W-1:0] s1_raddr_r;
  logic [COL_SH_W-1:0]   s1_col_r;
  logic                  fwd_a_r, fwd_b_r;
  logic [PIX_W-1:0]      fwd_data_r;
  logic [PIX_W-1:0]      rdata_a, rdata_b, data_a, data_b, s1_wdata;
  logic                  s1_we, s1_go;

  // Output register.
  logic                  out_valid_r, out_valid_nxt, out_free, out_ld_scan, out_ld_walk;
  logic                  out_kind_r, out_rej_r, out_last_r;
  logic [SUM_W-1:0]      out_sum_r;
  logic [RGB_W-1:0]      out_up_r, out_lo_r;
  logic [ROW_ADDR_W-1:0] out_raddr_r;
  logic [COL_SH_W-1:0]   out_col_r;

  // Walker hookup.
  logic              walk_busy, walk_re, walk_we;
  logic [ADDR_W-1:0] walk_addr;
  walk_res_t         walk_res;

  assign data_a   = fwd_a_r ? fwd_data_r : rdata_a;
  assign data_b   = fwd_b_r ? fwd_data_r : rdata_b;
  assign s1_wdata = s1_add_r ? data_a + s1_val_r : s1_val_r;
  assign s1_we    = s1_valid_r && s1_we_r;
  assign s1_go    = !s1_scan_r || out_free;
  assign out_free = !out_valid_r || out_tready;

  assign in_tready    = !walk_busy && (!s1_valid_r || s1_go);
  assign s1_valid_nxt = in_accept ? iss_to_s1 : (s1_valid_r && !s1_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      scan_row_r <= '0;
      scan_col_r <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      scan_row_r <= scan_row_nxt;
      scan_col_r <= scan_col_nxt;
    end
  end

  // A read issued while the previous beat writes the same entry returns the old byte,
  // so the new byte is captured here and used in its place.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_we_r    <= iss_we;
      s1_add_r   <= iss_add;
      s1_scan_r  <= iss_scan;
      s1_addr_r  <= iss_addr_a;
      s1_val_r   <= in_pix;
      s1_up_ok_r <= scan_up_ok;
      s1_lo_ok_r <= scan_lo_ok;
      s1_latch_r <= scan_latch;
      s1_raddr_r <= ROW_ADDR_W'(32'(scan_row_r));
      s1_col_r   <= COL_SH_W'(32'(scan_col_r));
      fwd_a_r    <= s1_we && (s1_addr_r == iss_addr_a);
      fwd_b_r    <= s1_we && (s1_addr_r == iss_addr_b);
      fwd_data_r <= s1_wdata;
    end
  end

  lmfs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (walk_we || s1_we),
    .waddr   (walk_we ? walk_addr : s1_addr_r),
    .wdata   (walk_we ? '0 : s1_wdata),
    .re_a    (walk_re || (in_accept && iss_to_s1)),
    .raddr_a (walk_busy ? walk_addr : iss_addr_a),
    .rdata_a (rdata_a),
    .re_b    (in_accept && iss_scan),
    .raddr_b (iss_addr_b),
    .rdata_b (rdata_b)
  );

  lmfs_rect_walk #(
    .PANEL_ROWS (PANEL_ROWS),
    .PANEL_COLS (PANEL_COLS)
  ) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept && iss_walk),
    .cmd      (walk_cmd),
    .busy     (walk_busy),
    .mem_re   (walk_re),
    .mem_we   (walk_we),
    .mem_addr (walk_addr),
    .rdata    (rdata_a),
    .res_take (out_free),
    .res      (walk_res)
  );

  // A scan result and a rectangle answer never compete: a rectangle beat is only taken
  // while the second stage is empty or drains in that cycle.
  assign out_ld_scan   = s1_valid_r && s1_scan_r && out_free;
  assign out_ld_walk   = walk_res.valid && out_free;
  assign out_valid_nxt = (out_ld_scan || out_ld_walk) ? 1'b1 :
                         (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld_scan) begin
      out_kind_r  <= 1'b0;
      out_sum_r   <= '0;
      out_rej_r   <= 1'b0;
      out_up_r    <= s1_up_ok_r ? data_a[RGB_W-1:0] : '0;
      out_lo_r    <= s1_lo_ok_r ? data_b[RGB_W-1:0] : '0;
      out_raddr_r <= s1_raddr_r;
      out_col_r   <= s1_col_r;
      out_last_r  <= s1_latch_r;
    end else if (out_ld_walk) begin
      out_kind_r  <= 1'b1;
      out_sum_r   <= walk_res.sum;
      out_rej_r   <= walk_res.rejected;
      out_up_r    <= '0;
      out_lo_r    <= '0;
      out_raddr_r <= '0;
      out_col_r   <= '0;
      out_last_r  <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {OUT_PAD_W'(0), out_col_r, out_raddr_r, out_lo_r, out_up_r,
                       out_rej_r, out_sum_r};

  // The walker and the second stage never drive the write port together.
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(walk_we && s1_we))
    else $error("walker and pixel stage write the store in the same cycle");

  // A beat pending in the second stage and a rectangle answer never coexist.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(walk_res.valid && s1_valid_r))
    else $error("rectangle answer ready while a pixel beat is still pending");

  // Clear all makes the walker busy in the next cycle.
  a_clear_all_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_op == OP_CLEAR_ALL) |=> walk_busy)
    else $error("clear all accepted but walker not busy");

  // The scan column wraps to zero after the latch beat.
  a_scan_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_op == OP_SCAN_STEP && scan_latch) |=> (scan_col_r == '0))
    else $error("scan column did not wrap after the last column");

endmodule

`default_nettype wire
